@@ rtl/core/block_cache_directory_macros.svh @@
// Assertion macros shared by the block cache directory RTL
`ifndef BLOCK_CACHE_DIRECTORY_MACROS_SVH
`define BLOCK_CACHE_DIRECTORY_MACROS_SVH

// Invariant checked at every clock edge outside reset
`define BCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after its condition
`define BCD_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);

`endif

@@ rtl/core/bcd_pkg.sv @@
// Types and constants of the block cache directory
package bcd_pkg;

  localparam int NUM_SLOTS = 64;
  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
  localparam int KEY_W     = 64;
  localparam int HITS_W    = 32;

  typedef enum logic [1:0] {
    KIND_FREE  = 2'd0,
    KIND_CLEAN = 2'd1,
    KIND_DIRTY = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_LOAD   = 3'd1,
    OP_MODIFY = 3'd2,
    OP_FLUSH  = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_NO_FREE = 2'd1,
    STS_CLEAN   = 2'd2,
    STS_ABSENT  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_EXEC,
    S_WALK1,
    S_WALK2,
    S_FIN
  } state_t;

  // passed from cell to cell
  typedef struct packed {
    logic cfound;
    logic dfound;
    logic tok;
  } link_t;

  // broadcast to every cell
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             ins;
    logic             bump;
    logic             mk_dirty;
    logic             walk1;
    logic             walk2;
    logic             keep;
  } cell_cmd_t;

  typedef struct packed {
    logic              chit;
    logic              dhit;
    logic              wclean;
    logic              wdirty;
    logic [HITS_W-1:0] hits;
  } cell_stat_t;

endpackage

@@ rtl/core/bcd_ram.sv @@
// Generic single write port RAM with registered read
module bcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                        clk,
  input  logic                                        wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                            wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule

@@ rtl/core/bcd_cell.sv @@
// One directory slot: kind, key and hit count, with lookup and walk links
module bcd_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  bcd_pkg::cell_cmd_t     cmd,
  input  logic                   sel_a,
  input  logic                   sel_b,
  input  bcd_pkg::link_t         link_in,
  output bcd_pkg::link_t         link_out,
  output bcd_pkg::cell_stat_t    stat
);

  bcd_pkg::kind_t                  kind_r, kind_nxt;
  logic [bcd_pkg::KEY_W-1:0]       key_r, key_nxt;
  logic [bcd_pkg::HITS_W-1:0]      hits_r, hits_nxt;
  logic                            tok_r;
  logic                            key_eq;
  logic                            is_clean;
  logic                            is_dirty;

  assign key_eq   = (key_r == cmd.key);
  assign is_clean = (kind_r == bcd_pkg::KIND_CLEAN);
  assign is_dirty = (kind_r == bcd_pkg::KIND_DIRTY);

  assign link_out.cfound = link_in.cfound | (is_clean & key_eq);
  assign link_out.dfound = link_in.dfound | (is_dirty & key_eq);
  assign link_out.tok    = tok_r;

  assign stat.chit   = is_clean & key_eq & ~link_in.cfound;
  assign stat.dhit   = is_dirty & key_eq & ~link_in.dfound;
  assign stat.wclean = tok_r & is_clean;
  assign stat.wdirty = tok_r & is_dirty;
  assign stat.hits   = hits_r;

  always_comb begin
    kind_nxt = kind_r;
    key_nxt  = key_r;
    hits_nxt = hits_r;
    if (sel_a) begin
      if (cmd.ins) begin
        kind_nxt = bcd_pkg::KIND_CLEAN;
        key_nxt  = cmd.key;
        hits_nxt = bcd_pkg::HITS_W'(1);
      end else if (cmd.bump) begin
        hits_nxt = (hits_r == '1) ? hits_r : hits_r + bcd_pkg::HITS_W'(1);
        if (cmd.mk_dirty) begin
          kind_nxt = bcd_pkg::KIND_DIRTY;
        end
      end
    end
    if (sel_b) begin
      kind_nxt = bcd_pkg::KIND_FREE;
    end
    if (tok_r && cmd.walk1 && is_clean) begin
      kind_nxt = bcd_pkg::KIND_FREE;
    end
    if (tok_r && cmd.walk2 && is_dirty) begin
      kind_nxt = cmd.keep ? bcd_pkg::KIND_CLEAN : bcd_pkg::KIND_FREE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= bcd_pkg::KIND_FREE;
      tok_r  <= 1'b0;
    end else begin
      kind_r <= kind_nxt;
      tok_r  <= link_in.tok;
    end
    key_r  <= key_nxt;
    hits_r <= hits_nxt;
  end

endmodule

@@ rtl/core/block_cache_directory.sv @@
// Block cache directory: slot chain, free slot queue and request sequencer
//
// Use: a request (op, block_key, file_offset, file_id) enters on in_valid when
// in_stall is low; exactly one result (status, slot, hits and the free, clean
// and dirty counts after the request) leaves on out_valid, held until out_stall
// is low. The entry attributes file_offset and file_id live with the block data
// outside this block; the slot output addresses that memory.
// Insert, load, modify and unused op codes load the result register after a
// broadcast key compare along the slot chain (S_LOOK), then the update (S_EXEC).
// A new request is taken only back in S_IDLE, once the last result is loaded.
// Flush and clear pass a token along the chain twice, one slot per cycle, and
// free slots into the queue in ascending order within each pass.
// The free slot queue is a RAM with one write and one read port; a slot is
// pushed at most once per cycle, which sets the walk length.
// Reset (synchronous, rst_n low) marks every slot free and the queue full in
// ascending order; no clearing pass is needed.
// While the result register is held by out_stall, a finished request waits in
// its last step and no further request is taken.
`include "block_cache_directory_macros.svh"

module block_cache_directory (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_op,
  input  logic [63:0] in_block_key,
  input  logic [63:0] in_file_offset,
  input  logic [31:0] in_file_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [5:0]  out_slot,
  output logic [31:0] out_hits,
  output logic [6:0]  out_free_count,
  output logic [6:0]  out_clean_count,
  output logic [6:0]  out_dirty_count
);

  localparam int N  = bcd_pkg::NUM_SLOTS;
  localparam int SW = bcd_pkg::SLOT_W;
  localparam int CW = bcd_pkg::CNT_W;
  localparam int HW = bcd_pkg::HITS_W;

  bcd_pkg::state_t           state_r, state_nxt;
  logic [2:0]                op_r;
  logic [bcd_pkg::KEY_W-1:0] key_r;
  logic [SW-1:0]             head_r, head_nxt;
  logic [CW-1:0]             fill_r, fill_nxt;
  logic [CW-1:0]             wcnt_r, wcnt_nxt;
  logic [CW-1:0]             clean_r, clean_nxt;
  logic [CW-1:0]             dirty_r, dirty_nxt;
  logic [SW-1:0]             idx_r, idx_nxt;
  logic                      keep_r, keep_nxt;
  logic                      chit_r, dhit_r;
  logic [SW-1:0]             cidx_r, didx_r;
  logic [HW-1:0]             chits_r, dhits_r;

  logic                      out_valid_r;
  logic [1:0]                out_status_r;
  logic [5:0]                out_slot_r;
  logic [HW-1:0]             out_hits_r;
  logic [6:0]                out_free_r, out_clean_r, out_dirty_r;

  bcd_pkg::cell_cmd_t        cmd;
  bcd_pkg::link_t            link [N+1];
  bcd_pkg::cell_stat_t       stat [N];
  logic [N-1:0]              sel_a_vec, sel_b_vec, tok_vec;
  logic                      sel_a_en, sel_b_en;
  logic [SW-1:0]             a_idx, b_idx;
  logic                      inj;

  logic                      c_any, d_any, wclean_any, wdirty_any;
  logic [SW-1:0]             c_idx, d_idx;
  logic [HW-1:0]             c_hits, d_hits;

  logic                      qwr_en;
  logic [SW-1:0]             qwr_data, q_rd, tail, head_slot;
  logic [CW:0]               tail_sum;

  logic                      go, last;
  logic                      res_load;
  bcd_pkg::status_t          res_status;
  logic [SW-1:0]             res_slot;
  logic [HW-1:0]             res_hits;

  assign link[0] = '{cfound: 1'b0, dfound: 1'b0, tok: inj};

  for (genvar i = 0; i < N; i++) begin : g_cell
    assign sel_a_vec[i] = sel_a_en && (a_idx == SW'(i));
    assign sel_b_vec[i] = sel_b_en && (b_idx == SW'(i));
    assign tok_vec[i]   = link[i+1].tok;
    bcd_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .sel_a    (sel_a_vec[i]),
      .sel_b    (sel_b_vec[i]),
      .link_in  (link[i]),
      .link_out (link[i+1]),
      .stat     (stat[i])
    );
  end

  always_comb begin
    c_any      = 1'b0;
    d_any      = 1'b0;
    wclean_any = 1'b0;
    wdirty_any = 1'b0;
    c_idx      = '0;
    d_idx      = '0;
    c_hits     = '0;
    d_hits     = '0;
    for (int i = 0; i < N; i++) begin
      if (stat[i].chit) begin
        c_any  = 1'b1;
        c_idx  = c_idx | SW'(i);
        c_hits = c_hits | stat[i].hits;
      end
      if (stat[i].dhit) begin
        d_any  = 1'b1;
        d_idx  = d_idx | SW'(i);
        d_hits = d_hits | stat[i].hits;
      end
      wclean_any = wclean_any | stat[i].wclean;
      wdirty_any = wdirty_any | stat[i].wdirty;
    end
  end

  // free slot queue; positions never written since reset are read as their own index
  bcd_ram #(
    .WIDTH (SW),
    .DEPTH (N)
  ) u_queue (
    .clk     (clk),
    .wr_en   (qwr_en),
    .wr_addr (tail),
    .wr_data (qwr_data),
    .rd_addr (head_r),
    .rd_data (q_rd)
  );

  assign tail_sum  = (CW+1)'(head_r) + (CW+1)'(fill_r);
  assign tail      = (tail_sum >= (CW+1)'(N)) ? SW'(tail_sum - (CW+1)'(N)) : SW'(tail_sum);
  assign head_slot = ((CW+1)'(head_r) < (CW+1)'(wcnt_r)) ? q_rd : head_r;
  assign wcnt_nxt  = (qwr_en && (wcnt_r != CW'(N))) ? wcnt_r + CW'(1) : wcnt_r;

  assign go   = !out_valid_r || !out_stall;
  assign last = (idx_r == SW'(N - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bcd_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = bcd_pkg::S_LOOK;
        end
      end
      bcd_pkg::S_LOOK: state_nxt = bcd_pkg::S_EXEC;
      bcd_pkg::S_EXEC: begin
        if (op_r == bcd_pkg::OP_FLUSH || op_r == bcd_pkg::OP_CLEAR) begin
          state_nxt = bcd_pkg::S_WALK1;
        end else if (go) begin
          state_nxt = bcd_pkg::S_IDLE;
        end
      end
      bcd_pkg::S_WALK1: begin
        if (last) begin
          state_nxt = bcd_pkg::S_WALK2;
        end
      end
      bcd_pkg::S_WALK2: begin
        if (last) begin
          state_nxt = bcd_pkg::S_FIN;
        end
      end
      bcd_pkg::S_FIN: begin
        if (go) begin
          state_nxt = bcd_pkg::S_IDLE;
        end
      end
      default: state_nxt = bcd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall     = 1'b1;
    cmd          = '0;
    cmd.key      = key_r;
    cmd.keep     = keep_r;
    sel_a_en     = 1'b0;
    sel_b_en     = 1'b0;
    a_idx        = '0;
    b_idx        = didx_r;
    inj          = 1'b0;
    qwr_en       = 1'b0;
    qwr_data     = idx_r;
    head_nxt     = head_r;
    fill_nxt     = fill_r;
    clean_nxt    = clean_r;
    dirty_nxt    = dirty_r;
    idx_nxt      = idx_r;
    keep_nxt     = keep_r;
    res_load     = 1'b0;
    res_status   = bcd_pkg::STS_OK;
    res_slot     = '0;
    res_hits     = '0;
    unique case (state_r)
      bcd_pkg::S_IDLE: in_stall = 1'b0;
      bcd_pkg::S_LOOK: ;
      bcd_pkg::S_EXEC: begin
        if (op_r == bcd_pkg::OP_FLUSH || op_r == bcd_pkg::OP_CLEAR) begin
          inj      = 1'b1;
          idx_nxt  = '0;
          keep_nxt = (op_r == bcd_pkg::OP_FLUSH) && (clean_r != '0);
        end else if (go) begin
          res_load = 1'b1;
          unique case (op_r)
            bcd_pkg::OP_INSERT: begin
              if (fill_r == '0) begin
                res_status = bcd_pkg::STS_NO_FREE;
              end else if (chit_r) begin
                res_status = bcd_pkg::STS_CLEAN;
                res_slot   = cidx_r;
                res_hits   = chits_r;
              end else begin
                sel_a_en  = 1'b1;
                a_idx     = head_slot;
                cmd.ins   = 1'b1;
                head_nxt  = (head_r == SW'(N - 1)) ? '0 : head_r + SW'(1);
                fill_nxt  = fill_r - CW'(1);
                clean_nxt = clean_r + CW'(1);
                res_slot  = head_slot;
                res_hits  = HW'(1);
              end
            end
            bcd_pkg::OP_LOAD, bcd_pkg::OP_MODIFY: begin
              if (chit_r) begin
                sel_a_en = 1'b1;
                a_idx    = cidx_r;
                cmd.bump = 1'b1;
                res_slot = cidx_r;
                res_hits = (chits_r == '1) ? chits_r : chits_r + HW'(1);
                if (op_r == bcd_pkg::OP_MODIFY) begin
                  cmd.mk_dirty = 1'b1;
                  clean_nxt    = clean_r - CW'(1);
                  dirty_nxt    = dirty_r + CW'(1);
                  if (dhit_r) begin
                    sel_b_en  = 1'b1;
                    qwr_en    = 1'b1;
                    qwr_data  = didx_r;
                    fill_nxt  = fill_r + CW'(1);
                    dirty_nxt = dirty_r;
                  end
                end
              end else if (dhit_r) begin
                sel_a_en = 1'b1;
                a_idx    = didx_r;
                cmd.bump = 1'b1;
                res_slot = didx_r;
                res_hits = (dhits_r == '1) ? dhits_r : dhits_r + HW'(1);
              end else begin
                res_status = bcd_pkg::STS_ABSENT;
              end
            end
            default: ;
          endcase
        end
      end
      bcd_pkg::S_WALK1: begin
        cmd.walk1 = 1'b1;
        if (wclean_any) begin
          qwr_en    = 1'b1;
          fill_nxt  = fill_r + CW'(1);
          clean_nxt = clean_r - CW'(1);
        end
        if (last) begin
          inj     = 1'b1;
          idx_nxt = '0;
        end else begin
          idx_nxt = idx_r + SW'(1);
        end
      end
      bcd_pkg::S_WALK2: begin
        cmd.walk2 = 1'b1;
        if (wdirty_any) begin
          dirty_nxt = dirty_r - CW'(1);
          if (keep_r) begin
            clean_nxt = clean_r + CW'(1);
          end else begin
            qwr_en   = 1'b1;
            fill_nxt = fill_r + CW'(1);
          end
        end
        idx_nxt = last ? '0 : idx_r + SW'(1);
      end
      bcd_pkg::S_FIN: res_load = go;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bcd_pkg::S_IDLE;
      head_r      <= '0;
      fill_r      <= CW'(N);
      wcnt_r      <= '0;
      clean_r     <= '0;
      dirty_r     <= '0;
      idx_r       <= '0;
      keep_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      fill_r  <= fill_nxt;
      wcnt_r  <= wcnt_nxt;
      clean_r <= clean_nxt;
      dirty_r <= dirty_nxt;
      idx_r   <= idx_nxt;
      keep_r  <= keep_nxt;
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (state_r == bcd_pkg::S_IDLE && in_valid) begin
      op_r  <= in_op;
      key_r <= in_block_key;
    end
    if (state_r == bcd_pkg::S_LOOK) begin
      chit_r  <= c_any;
      dhit_r  <= d_any;
      cidx_r  <= c_idx;
      didx_r  <= d_idx;
      chits_r <= c_hits;
      dhits_r <= d_hits;
    end
    if (res_load) begin
      out_status_r <= res_status;
      out_slot_r   <= 6'(res_slot);
      out_hits_r   <= res_hits;
      out_free_r   <= 7'(fill_nxt);
      out_clean_r  <= 7'(clean_nxt);
      out_dirty_r  <= 7'(dirty_nxt);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_slot        = out_slot_r;
  assign out_hits        = out_hits_r;
  assign out_free_count  = out_free_r;
  assign out_clean_count = out_clean_r;
  assign out_dirty_count = out_dirty_r;

  `BCD_ASSERT(a_slot_total, ((CW+2)'(fill_r) + (CW+2)'(clean_r) + (CW+2)'(dirty_r) == (CW+2)'(N)), "slot counts do not add up")
  `BCD_ASSERT(a_one_token, $onehot0(tok_vec), "more than one walk token in the chain")
  `BCD_ASSERT(a_push_room, (!qwr_en || (fill_r != CW'(N))), "free queue push while queue full")
  `BCD_ASSERT_NEXT(a_insert_pops, (sel_a_en && cmd.ins), (fill_r + CW'(1) == $past(fill_r)), "insert did not take a free slot")

endmodule
